>>> sv/rse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg: shared types, constants and Galois-field helpers
// Field width, parity depth, payload structs and cell control for the
// Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int SYMBOL_BITS    = 8;
    localparam int MAX_PARITY     = 32;
    localparam int CNT_BITS       = $clog2(MAX_PARITY + 1);
    localparam int PARCNT_BITS    = 6;
    localparam int POLY_BITS      = 9;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PARITY_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_POLY   = 2'd1;

    localparam logic [PARCNT_BITS-1:0] PARITY_COUNT_RESET = 6'd16;
    localparam logic [POLY_BITS-1:0]   FIELD_POLY_RESET   = 9'd285;

    typedef logic [SYMBOL_BITS-1:0] t_sym;

    typedef struct packed {
        logic [7:0] data_symbol;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] code_symbol;
        logic       is_parity;
        logic       codeword_end;
    } t_out_item;

    // Commands broadcast to every cell of the chain
    typedef struct packed {
        logic clear;   // zero generator tap and remainder
        logic build;   // multiply the generator by (x + root)
        logic shift;   // advance the remainder one place
        t_sym coef;    // feedback symbol for a shift
        t_sym root;    // root for a build step
        t_sym poly;    // field polynomial, implied top term dropped
    } t_cell_ctl;

    function automatic t_sym gf_xtime(input t_sym v, input t_sym poly);
        gf_xtime = {v[SYMBOL_BITS-2:0], 1'b0} ^ (v[SYMBOL_BITS-1] ? poly : '0);
    endfunction

    function automatic t_sym gf_mul(input t_sym a, input t_sym b, input t_sym poly);
        t_sym acc;
        acc = '0;
        for (int bit_i = SYMBOL_BITS - 1; bit_i >= 0; bit_i--) begin
            acc = gf_xtime(acc, poly);
            if (b[bit_i]) begin
                acc = acc ^ a;
            end
        end
        gf_mul = acc;
    endfunction

endpackage
`default_nettype wire

>>> sv/rse_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rse_cell: one stage of the encoder chain
// Holds one generator tap and one remainder symbol; builds the tap from its
// left neighbor and shifts the remainder in from its right neighbor.
// ----------------------------------------------------------------------------
module rse_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rse_pkg::t_cell_ctl i_ctl,
    input  wire rse_pkg::t_sym     i_tap_left,
    input  wire rse_pkg::t_sym     i_rem_right,
    output rse_pkg::t_sym          o_tap,
    output rse_pkg::t_sym          o_rem
);

    rse_pkg::t_sym r_tap;
    rse_pkg::t_sym r_rem;
    rse_pkg::t_sym w_mul_a;
    rse_pkg::t_sym w_mul_b;
    rse_pkg::t_sym w_prod;

    // One multiplier serves both the generator build and the division step
    always_comb begin
        w_mul_a = i_ctl.build ? i_ctl.root : i_ctl.coef;
        w_mul_b = i_ctl.build ? i_tap_left : r_tap;
        w_prod  = rse_pkg::gf_mul(w_mul_a, w_mul_b, i_ctl.poly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
            r_rem <= '0;
        end else if (i_ctl.clear) begin
            r_tap <= '0;
            r_rem <= '0;
        end else begin
            if (i_ctl.build) begin
                r_tap <= r_tap ^ w_prod;
            end
            if (i_ctl.shift) begin
                r_rem <= i_rem_right ^ w_prod;
            end
        end
    end

    assign o_tap = r_tap;
    assign o_rem = r_rem;

endmodule
`default_nettype wire

>>> sv/reed_solomon_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reed_solomon_encoder: systematic Reed-Solomon encoder
// Echoes each data symbol and appends n parity symbols after the block end,
// using a chain of cells that holds the generator taps and the remainder.
// ----------------------------------------------------------------------------
// An input transfer's echoed symbol is in the output register in the cycle after the transfer.
// Throughput: one symbol per cycle while the output is not stalled; after the block-end
//   symbol the input is held off while the n parity symbols drain from cell 0.
// Reset and every write to a defined register clear the chain and rebuild the
//   generator, one factor per cycle (n = effective parity count,
//   1 to 32); the input is held off during the build.
module reed_solomon_encoder (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // data input
    input  wire logic                                  i_in_valid,
    input  wire rse_pkg::t_in_item                     i_in_data,
    output logic                                       o_in_stall,
    // code output
    output logic                                       o_out_valid,
    output rse_pkg::t_out_item                         o_out_data,
    input  wire logic                                  i_out_stall,
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    input  wire logic [rse_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [rse_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                       o_cfg_ready
);

    localparam int SB  = rse_pkg::SYMBOL_BITS;
    localparam int MP  = rse_pkg::MAX_PARITY;
    localparam int CB  = rse_pkg::CNT_BITS;
    localparam int PCB = rse_pkg::PARCNT_BITS;
    localparam int PB  = rse_pkg::POLY_BITS;

    // Configuration registers
    logic [PCB-1:0] r_parity_count;
    logic [PB-1:0]  r_field_poly;

    // Sequencing
    logic [CB-1:0]  r_build_cnt;     // generator factors still to apply
    logic [CB-1:0]  r_unload_cnt;    // parity symbols still to emit
    rse_pkg::t_sym  r_root;          // alpha^i of the last factor applied

    // Output register
    logic               r_out_valid;
    rse_pkg::t_out_item r_out_data;

    // Chain wiring
    rse_pkg::t_sym     w_tap [MP];
    rse_pkg::t_sym     w_rem [MP];
    rse_pkg::t_cell_ctl w_ctl;

    logic [CB-1:0]  w_n_eff;
    logic [CB-1:0]  w_n_new;
    logic [PCB-1:0] w_pc_new;
    logic [PCB-1:0] w_pc_eval;
    logic [PB-1:0]  w_poly_new;
    rse_pkg::t_sym  w_poly_sym;
    rse_pkg::t_sym  w_root_next;
    rse_pkg::t_sym  w_data_sym;
    logic           w_building;
    logic           w_unloading;
    logic           w_out_ready;
    logic           w_in_xfer;
    logic           w_unload_step;
    logic           w_cfg_xfer;
    logic           w_cfg_hit;

    // Clamp a parity count into 1 .. MAX_PARITY
    function automatic logic [CB-1:0] clamp_count(input logic [PCB-1:0] pc);
        if (pc == '0) begin
            clamp_count = CB'(1);
        end else if (pc > PCB'(MP)) begin
            clamp_count = CB'(MP);
        end else begin
            clamp_count = CB'(pc);
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit   = w_cfg_xfer && ((i_cfg_index == rse_pkg::CFG_PARITY_COUNT) ||
                                        (i_cfg_index == rse_pkg::CFG_FIELD_POLY));

    // Register values as they stand after this cycle's write
    always_comb begin
        w_pc_new   = r_parity_count;
        w_poly_new = r_field_poly;
        if (w_cfg_xfer && (i_cfg_index == rse_pkg::CFG_PARITY_COUNT)) begin
            w_pc_new = i_cfg_data[PCB-1:0];
        end
        if (w_cfg_xfer && (i_cfg_index == rse_pkg::CFG_FIELD_POLY)) begin
            w_poly_new = i_cfg_data[PB-1:0];
        end
        w_pc_eval = w_pc_new;
    end

    assign w_n_eff     = clamp_count(r_parity_count);
    assign w_n_new     = clamp_count(w_pc_eval);
    assign w_poly_sym  = r_field_poly[SB-1:0];
    assign w_root_next = rse_pkg::gf_xtime(r_root, w_poly_sym);
    assign w_data_sym  = i_in_data.data_symbol[SB-1:0];

    assign w_building    = (r_build_cnt != '0);
    assign w_unloading   = (r_unload_cnt != '0);
    assign w_out_ready   = !r_out_valid || !i_out_stall;

    // Hold input while the generator builds, parity drains or output is full
    assign o_in_stall    = w_building || w_unloading || !w_out_ready;
    assign w_in_xfer     = i_in_valid && !o_in_stall;
    assign w_unload_step = w_unloading && w_out_ready;

    // Chain commands: a data symbol divides, a drain step shifts with zero feedback
    always_comb begin
        w_ctl.clear = w_cfg_hit;
        w_ctl.build = w_building && !w_cfg_hit;
        w_ctl.shift = w_in_xfer || w_unload_step;
        w_ctl.coef  = w_in_xfer ? (w_data_sym ^ w_rem[0]) : '0;
        w_ctl.root  = w_root_next;
        w_ctl.poly  = w_poly_sym;
    end

    // Cell 0 sees the implied leading 1 on its left; the last cell shifts in zero
    for (genvar g = 0; g < MP; g++) begin : g_cell
        rse_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_tap_left  ((g == 0) ? SB'(1) : w_tap[(g == 0) ? 0 : g - 1]),
            .i_rem_right ((g == MP - 1) ? '0 : w_rem[(g == MP - 1) ? g : g + 1]),
            .o_tap       (w_tap[g]),
            .o_rem       (w_rem[g])
        );
    end

    // Configuration and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_count <= rse_pkg::PARITY_COUNT_RESET;
            r_field_poly   <= rse_pkg::FIELD_POLY_RESET;
            r_build_cnt    <= clamp_count(rse_pkg::PARITY_COUNT_RESET);
            r_root         <= SB'(1);
            r_unload_cnt   <= '0;
        end else begin
            r_parity_count <= w_pc_new;
            r_field_poly   <= w_poly_new;
            if (w_cfg_hit) begin
                // restart the build and drop any codeword in progress
                r_build_cnt  <= w_n_new;
                r_root       <= SB'(1);
                r_unload_cnt <= '0;
            end else begin
                if (w_building) begin
                    r_build_cnt <= r_build_cnt - CB'(1);
                    r_root      <= w_root_next;
                end
                if (w_in_xfer && i_in_data.block_end) begin
                    r_unload_cnt <= w_n_eff;
                end else if (w_unload_step) begin
                    r_unload_cnt <= r_unload_cnt - CB'(1);
                end
            end
        end
    end

    // Output register: echo a data symbol or emit the next parity symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_in_xfer || w_unload_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            if (w_unload_step) begin
                r_out_data.code_symbol  <= 8'(w_rem[0]);
                r_out_data.is_parity    <= 1'b1;
                r_out_data.codeword_end <= (r_unload_cnt == CB'(1));
            end else begin
                r_out_data.code_symbol  <= 8'(w_data_sym);
                r_out_data.is_parity    <= 1'b0;
                r_out_data.codeword_end <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Build and parity drain never overlap
    a_build_unload_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_building && w_unloading))
        else $error("generator build overlaps parity drain");

    // A codeword end is always a parity symbol
    a_end_is_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.codeword_end) |-> o_out_data.is_parity)
        else $error("codeword end on a non-parity symbol");

    // The remainder is empty once the final parity symbol has left the chain
    a_rem_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_unload_step && (r_unload_cnt == CB'(1))) |=> (w_rem[0] == '0))
        else $error("remainder not cleared after codeword");

endmodule
`default_nettype wire

>>> sim/tb_reed_solomon_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_reed_solomon_encoder: self-checking bench for the systematic RS encoder
// Feeds message symbols through the data port, rebuilds the generator and the
// remainder in a bench-side encoder model at every defined register write, and checks
// each echoed and parity symbol in order against the model's prediction.
// ----------------------------------------------------------------------------
module tb_reed_solomon_encoder;

    // Indexes outside the register file; writes to them must be ignored
    localparam logic [rse_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [rse_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_B = 2'd3;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 200;
    localparam int PHASE_ITEMS    = 30;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    rse_pkg::t_in_item                  i_in_data = '0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    rse_pkg::t_out_item                 o_out_data;
    logic                               i_out_stall = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [rse_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [rse_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                               o_cfg_ready;

    reed_solomon_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench-side encoder: register copies, generator taps and LFSR remainder
    // ------------------------------------------------------------------------
    logic [rse_pkg::PARCNT_BITS-1:0] parity_count_reg;
    logic [rse_pkg::POLY_BITS-1:0]   field_poly_reg;
    logic [7:0] gen_taps [rse_pkg::MAX_PARITY];   // entry k holds the x^k coefficient
    logic [7:0] remainder [rse_pkg::MAX_PARITY];  // entry 0 is the highest degree
    int         active_parity;

    rse_pkg::t_out_item expected_code [$];     // symbols still owed by the encoder
    rse_pkg::t_in_item  pending_symbols [$];   // message symbols not yet transferred

    int items_queued = 0;
    int items_taken = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic in_taken = 1'b0;
    rse_pkg::t_out_item wanted;

    // Multiply by x, reducing by the low byte of the field polynomial
    function automatic logic [7:0] field_double(input logic [7:0] v, input logic [7:0] poly);
        field_double = {v[6:0], 1'b0} ^ (v[7] ? poly : 8'h00);
    endfunction

    // Shift-and-add product, low bit of b first
    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] acc;
        logic [7:0] addend;
        acc = 8'h00;
        addend = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ addend;
            end
            addend = field_double(addend, poly);
        end
        field_mul = acc;
    endfunction

    // Build g(x) = (x + a^1)...(x + a^n) and clear the remainder
    function automatic void rebuild_generator();
        logic [7:0] g [rse_pkg::MAX_PARITY+1];
        logic [7:0] root;
        logic [7:0] poly;
        poly = field_poly_reg[7:0];
        active_parity = int'(parity_count_reg);
        if (active_parity < 1) begin
            active_parity = 1;
        end
        if (active_parity > rse_pkg::MAX_PARITY) begin
            active_parity = rse_pkg::MAX_PARITY;
        end
        for (int j = 0; j <= rse_pkg::MAX_PARITY; j++) begin
            g[j] = 8'h00;
        end
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < active_parity; i++) begin
            root = field_double(root, poly);
            for (int j = i + 1; j >= 1; j--) begin
                g[j] = g[j-1] ^ field_mul(g[j], root, poly);
            end
            g[0] = field_mul(g[0], root, poly);
        end
        for (int i = 0; i < rse_pkg::MAX_PARITY; i++) begin
            gen_taps[i] = (i < active_parity) ? g[i] : 8'h00;
            remainder[i] = 8'h00;
        end
    endfunction

    function automatic void apply_register_write(
        input logic [rse_pkg::CFG_INDEX_BITS-1:0] idx,
        input logic [rse_pkg::CFG_DATA_BITS-1:0]  data);
        case (idx)
            rse_pkg::CFG_PARITY_COUNT: begin
                parity_count_reg = data[rse_pkg::PARCNT_BITS-1:0];
                rebuild_generator();
            end
            rse_pkg::CFG_FIELD_POLY: begin
                field_poly_reg = data[rse_pkg::POLY_BITS-1:0];
                rebuild_generator();
            end
            default: ;
        endcase
    endfunction

    // Echo one symbol, advance the LFSR and, on a block end, flush the parity
    function automatic void encode_symbol(input rse_pkg::t_in_item item);
        logic [7:0] coef;
        logic [7:0] poly;
        int         n;
        poly = field_poly_reg[7:0];
        n = active_parity;
        expected_code.push_back(rse_pkg::t_out_item'{code_symbol: item.data_symbol,
                                                     is_parity: 1'b0,
                                                     codeword_end: 1'b0});
        coef = item.data_symbol ^ remainder[0];
        for (int j = 0; j + 1 < n; j++) begin
            remainder[j] = remainder[j+1];
        end
        remainder[n-1] = 8'h00;
        for (int j = 0; j < n; j++) begin
            remainder[j] = remainder[j] ^ field_mul(gen_taps[n-1-j], coef, poly);
        end
        if (item.block_end) begin
            for (int j = 0; j < n; j++) begin
                expected_code.push_back(rse_pkg::t_out_item'{code_symbol: remainder[j],
                                                             is_parity: 1'b1,
                                                             codeword_end: (j == n - 1)});
            end
            for (int j = 0; j < rse_pkg::MAX_PARITY; j++) begin
                remainder[j] = 8'h00;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        if (i_rst_n) begin
            // Drop the symbol that went through on the last rising edge
            if (in_taken) begin
                void'(pending_symbols.pop_front());
            end
            if (i_in_valid && !in_taken) begin
                // Hold the stalled transfer unchanged
            end else if (pending_symbols.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_symbols[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge, check, and predict
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;

            // Check output first so a symbol accepted on this edge cannot
            // stand in for an output transfer that nobody was owed
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_code.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected code symbol %02h parity %0b end %0b",
                                 $time, o_out_data.code_symbol, o_out_data.is_parity,
                                 o_out_data.codeword_end);
                    end
                end else begin
                    wanted = expected_code.pop_front();
                    if (o_out_data !== wanted) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display({"%0t: code mismatch: expected symbol %02h parity %0b ",
                                      "end %0b, got symbol %02h parity %0b end %0b"},
                                     $time, wanted.code_symbol, wanted.is_parity,
                                     wanted.codeword_end, o_out_data.code_symbol,
                                     o_out_data.is_parity, o_out_data.codeword_end);
                        end
                    end
                end
            end

            if (i_in_valid && !o_in_stall) begin
                encode_symbol(i_in_data);
                items_taken++;
            end

            // Count stuck cycles only while work is outstanding
            if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else if (items_taken != items_queued || expected_code.size() != 0 ||
                         i_cfg_valid) begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; settle and write_register return just after a rising edge
    // ------------------------------------------------------------------------
    task automatic queue_symbol(input logic [7:0] sym, input logic last);
        pending_symbols.push_back(rse_pkg::t_in_item'{data_symbol: sym, block_end: last});
        items_queued++;
    endtask

    // Hold off until every queued symbol went through and every result came back
    task automatic settle();
        while (items_taken != items_queued || expected_code.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic [rse_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [rse_pkg::CFG_DATA_BITS-1:0]  data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        apply_register_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick new register settings, leaning on the extremes
    task automatic random_config();
        logic [rse_pkg::CFG_DATA_BITS-1:0] value;
        if ($urandom_range(2) != 0) begin
            case ($urandom_range(4))
                0:       value = 9'd0;
                1:       value = 9'd63;
                2:       value = 9'd32;
                default: value = 9'($urandom_range(511));
            endcase
            write_register(rse_pkg::CFG_PARITY_COUNT, value);
        end
        if ($urandom_range(2) != 0) begin
            case ($urandom_range(3))
                0:       value = 9'd285;
                1:       value = 9'd0;
                2:       value = 9'd511;
                default: value = 9'($urandom_range(511));
            endcase
            write_register(rse_pkg::CFG_FIELD_POLY, value);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int  sent;
        int  len;
        logic broken;

        parity_count_reg = rse_pkg::PARITY_COUNT_RESET;
        field_poly_reg   = rse_pkg::FIELD_POLY_RESET;
        rebuild_generator();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. Reset settings: 16 parity, field 0x11D
        queue_symbol(8'h00, 1'b0);
        queue_symbol(8'hFF, 1'b0);
        queue_symbol(8'h80, 1'b0);
        queue_symbol(8'h01, 1'b1);
        queue_symbol(8'hFF, 1'b1);              // one-symbol message

        // Abandon a message with a write; parity count zero acts as one
        queue_symbol(8'h5A, 1'b0);
        queue_symbol(8'hA5, 1'b0);
        queue_symbol(8'h3C, 1'b0);
        settle();
        write_register(rse_pkg::CFG_PARITY_COUNT, 9'd0);
        queue_symbol(8'h7E, 1'b0);
        queue_symbol(8'h81, 1'b1);

        // Parity count above the maximum saturates
        settle();
        write_register(rse_pkg::CFG_PARITY_COUNT, 9'd63);
        queue_symbol(8'hC3, 1'b0);
        queue_symbol(8'h24, 1'b0);
        queue_symbol(8'hE7, 1'b1);

        // Degenerate field polynomials: all zero, all ones, top bit only
        settle();
        write_register(rse_pkg::CFG_FIELD_POLY, 9'd0);
        queue_symbol(8'h9B, 1'b0);
        queue_symbol(8'h64, 1'b1);
        settle();
        write_register(rse_pkg::CFG_FIELD_POLY, 9'h1FF);
        queue_symbol(8'h12, 1'b0);
        queue_symbol(8'hED, 1'b1);
        settle();
        write_register(rse_pkg::CFG_PARITY_COUNT, 9'h1C5);   // upper data bits are dropped
        write_register(rse_pkg::CFG_FIELD_POLY, 9'h100);
        queue_symbol(8'hF0, 1'b1);

        // Writes to unused indexes must leave a message in progress intact
        queue_symbol(8'h0F, 1'b0);
        queue_symbol(8'h55, 1'b0);
        settle();
        write_register(CFG_UNUSED_A, 9'h1FF);
        write_register(CFG_UNUSED_B, 9'h0AA);
        queue_symbol(8'hAA, 1'b1);

        settle();
        write_register(rse_pkg::CFG_FIELD_POLY, 9'd285);
        write_register(rse_pkg::CFG_PARITY_COUNT, 9'd1);
        queue_symbol(8'h33, 1'b1);
        settle();
        write_register(rse_pkg::CFG_PARITY_COUNT, 9'd2);
        queue_symbol(8'hCC, 1'b0);
        queue_symbol(8'h99, 1'b1);

        // Random part: one phase per idling mode, each starting from a drained
        // pipe so the sender also pauses until every result has come back
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
                default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            endcase
            random_config();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
                broken = ($urandom_range(9) == 0);
                for (int k = 0; k < len; k++) begin
                    queue_symbol(8'($urandom_range(255)), !broken && (k == len - 1));
                end
                sent += len;
                // A message cut short is dropped by the next register write
                if (broken) begin
                    settle();
                    random_config();
                end
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
